/* design/c32w_pkg.sv */
// Package for the CRC-32C word engine: widths, payload types and the
// constant column tables of the byte-lane XOR network. No dependencies.
package c32w_pkg;

    localparam int unsigned BYTES_PER_WORD = 8;
    localparam int unsigned DATA_W         = 8 * BYTES_PER_WORD;
    localparam int unsigned CRC_W          = 32;
    localparam int unsigned CNT_W          = 4;
    localparam int unsigned DIST_W         = $clog2(BYTES_PER_WORD + 1);

    localparam logic [CRC_W-1:0] CRC_POLY = 32'h82F63B78;
    localparam logic [CRC_W-1:0] CRC_INIT = '1;

    typedef logic [CRC_W-1:0] crc_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [DIST_W-1:0] dist_t;

    // One column per input bit: the effect of that bit after d byte steps.
    typedef crc_t [7:0] byte_cols_t;
    typedef byte_cols_t [BYTES_PER_WORD:0] byte_tab_t;
    typedef crc_t [CRC_W-1:0] state_cols_t;
    typedef state_cols_t [BYTES_PER_WORD:0] state_tab_t;
    typedef crc_t [BYTES_PER_WORD-1:0] lane_vec_t;

    typedef struct packed {
        crc_t checksum;
        logic message_done;
    } result_t;

    // Advance a reflected CRC through n all-zero bytes (elaboration only).
    function automatic crc_t zero_bytes(crc_t c, int unsigned n);
        crc_t r;
        r = c;
        for (int unsigned k = 0; k < 8 * n; k++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic byte_tab_t build_byte_tab();
        byte_tab_t t;
        for (int unsigned d = 0; d <= BYTES_PER_WORD; d++)
        begin
            for (int unsigned b = 0; b < 8; b++)
            begin
                t[d][b] = zero_bytes(crc_t'(1) << b, d);
            end
        end
        return t;
    endfunction

    function automatic state_tab_t build_state_tab();
        state_tab_t t;
        for (int unsigned n = 0; n <= BYTES_PER_WORD; n++)
        begin
            for (int unsigned j = 0; j < CRC_W; j++)
            begin
                t[n][j] = zero_bytes(crc_t'(1) << j, n);
            end
        end
        return t;
    endfunction

    localparam byte_tab_t  BYTE_TAB  = build_byte_tab();
    localparam state_tab_t STATE_TAB = build_state_tab();

endpackage

/* design/c32w_ifs.sv */
// Valid/ready channel interfaces for the CRC-32C word engine.
// Depends on c32w_pkg for field widths.
interface c32w_in_if import c32w_pkg::*; ();
    logic              valid;
    logic              ready;
    crc_t              seed_value;
    logic [DATA_W-1:0] data_word;
    cnt_t              byte_count;
    logic              first_item;
    logic              last_item;

    modport source (output valid, seed_value, data_word, byte_count, first_item, last_item,
                    input ready);
    modport sink   (input valid, seed_value, data_word, byte_count, first_item, last_item,
                    output ready);
endinterface

interface c32w_out_if import c32w_pkg::*; ();
    logic valid;
    logic ready;
    crc_t checksum;
    logic message_done;

    modport source (output valid, checksum, message_done, input ready);
    modport sink   (input valid, checksum, message_done, output ready);
endinterface

/* design/c32w_lane.sv */
// One byte lane: contribution of a message byte that sits a given number
// of byte steps before the end of the transaction. Uses c32w_pkg tables.
module c32w_lane import c32w_pkg::*;
(
    input  logic [7:0] byte_data,
    input  dist_t      distance,
    input  logic       enable,
    output crc_t       contrib
);

    always_comb
    begin
        contrib = '0;
        if (enable)
        begin
            for (int unsigned t = 0; t < 8; t++)
            begin
                if (byte_data[t])
                begin
                    contrib = contrib ^ BYTE_TAB[distance][t];
                end
            end
        end
    end

endmodule

/* design/c32w_merge.sv */
// Merge stage: advances the starting register over count bytes and XORs
// in every lane's contribution. Uses c32w_pkg tables.
module c32w_merge import c32w_pkg::*;
(
    input  crc_t      start_crc,
    input  dist_t     count,
    input  lane_vec_t lane_contrib,
    output crc_t      next_crc
);

    crc_t state_term;

    always_comb
    begin
        state_term = '0;
        for (int unsigned j = 0; j < CRC_W; j++)
        begin
            if (start_crc[j])
            begin
                state_term = state_term ^ STATE_TAB[count][j];
            end
        end
        next_crc = state_term;
        for (int unsigned i = 0; i < BYTES_PER_WORD; i++)
        begin
            next_crc = next_crc ^ lane_contrib[i];
        end
    end

endmodule

/* design/c32w_out_stage.sv */
// Two-entry output buffer (result register plus skid register) so a new
// transaction is taken while a result waits. Depends on c32w_pkg.
module c32w_out_stage import c32w_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_data,
    output logic    can_accept,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;
    logic    out_fire;

    assign out_fire   = out_valid_reg & out_ready;
    assign can_accept = ~skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (load)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_data_next  = load_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = load_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

/* design/crc32c_word_engine_top.sv */
// CRC-32C word engine, reflected polynomial 0x82F63B78, up to 8 bytes a transaction.
// Result: registered in the output stage when the input transaction is accepted.
// Throughput: 1 transaction per cycle while the skid register is empty, set by the
// running CRC feedback through the 8 byte lanes and the merge XOR network.
// Reset: running CRC to all ones, result and skid registers empty.
module crc32c_word_engine_top import c32w_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    c32w_in_if.sink           in_chan,
    c32w_out_if.source        out_chan
);

    crc_t      running_crc_reg, running_crc_next;
    dist_t     count_sat;
    crc_t      start_crc;
    lane_vec_t lane_contrib;
    result_t   new_result;
    result_t   out_data;
    logic      can_accept;
    logic      in_fire;

    assign in_chan.ready = can_accept;
    assign in_fire       = in_chan.valid & can_accept;

    assign count_sat = (in_chan.byte_count > CNT_W'(BYTES_PER_WORD))
                     ? DIST_W'(BYTES_PER_WORD)
                     : DIST_W'(in_chan.byte_count);
    assign start_crc = in_chan.first_item ? ~in_chan.seed_value : running_crc_reg;

    for (genvar i = 0; i < BYTES_PER_WORD; i++)
    begin : g_lane
        c32w_lane u_lane
        (
            .byte_data (in_chan.data_word[8*i +: 8]),
            .distance  (count_sat - DIST_W'(i)),
            .enable    (DIST_W'(i) < count_sat),
            .contrib   (lane_contrib[i])
        );
    end

    c32w_merge u_merge
    (
        .start_crc    (start_crc),
        .count        (count_sat),
        .lane_contrib (lane_contrib),
        .next_crc     (running_crc_next)
    );

    assign new_result.checksum     = ~running_crc_next;
    assign new_result.message_done = in_chan.last_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_crc_reg <= CRC_INIT;
        end
        else if (in_fire)
        begin
            running_crc_reg <= running_crc_next;
        end
    end

    c32w_out_stage u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (in_fire),
        .load_data  (new_result),
        .can_accept (can_accept),
        .out_valid  (out_chan.valid),
        .out_ready  (out_chan.ready),
        .out_data   (out_data)
    );

    assign out_chan.checksum     = out_data.checksum;
    assign out_chan.message_done = out_data.message_done;

endmodule
